>>> hw/rtl/rmoa_pkg.sv
// Shared constants, types and register codes for the region motion overlap alarm.
`timescale 1ns / 1ps
`default_nettype none
package rmoa_pkg;

    localparam int MAX_REGIONS     = 4;
    localparam int REGION_IDX_W    = 2;
    localparam int DEF_NUM_REGIONS = 4;
    localparam int DEF_COORD_BITS  = 12;
    localparam int IN_COORD_W      = 12;
    localparam int SECS_W          = 17;
    localparam int BOUND_W         = 64;
    localparam int FIELD_W         = 16;
    localparam int SENS_W          = 7;
    localparam int SENS_SET_W      = MAX_REGIONS * SENS_W;
    localparam int DAY_WIN_W       = 36;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int ACC_W           = 32;
    localparam int HITS_W          = MAX_REGIONS;

    localparam logic KIND_RECT = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_REGION0    = 3'd1,
        CFG_REGION1    = 3'd2,
        CFG_REGION2    = 3'd3,
        CFG_REGION3    = 3'd4,
        CFG_SENS_CD    = 3'd5,
        CFG_SENS_NIGHT = 3'd6,
        CFG_DAY_WINDOW = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DN_OFF   = 2'd0,
        DN_AUTO  = 2'd1,
        DN_SCHED = 2'd2
    } t_dn_mode;

    typedef enum logic [1:0] {
        SENS_CLOSE = 2'd0,
        SENS_DAY   = 2'd1,
        SENS_NIGHT = 2'd2
    } t_sens_sel;

    typedef struct packed {
        logic                                  enable;
        logic [MAX_REGIONS-1:0][BOUND_W-1:0]   region_bounds;
        logic [2*SENS_SET_W-1:0]               sens_close_day;
        logic [SENS_SET_W-1:0]                 sens_night;
        logic [DAY_WIN_W-1:0]                  day_window;
    } t_cfg;

    // queued command: {kind, sens_sel, min_x, max_x, min_y, max_y}
    function automatic int cmd_width(input int coord_bits);
        return 3 + 4 * coord_bits;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rmoa_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface rmoa_req_if
    import rmoa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [IN_COORD_W-1:0] corner0_x;
    logic [IN_COORD_W-1:0] corner0_y;
    logic [IN_COORD_W-1:0] corner1_x;
    logic [IN_COORD_W-1:0] corner1_y;
    logic [IN_COORD_W-1:0] corner2_x;
    logic [IN_COORD_W-1:0] corner2_y;
    logic [IN_COORD_W-1:0] corner3_x;
    logic [IN_COORD_W-1:0] corner3_y;
    logic                  night_now;
    logic [SECS_W-1:0]     seconds_of_day;

    modport source (
        output valid, kind, corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y, night_now, seconds_of_day,
        input  ready
    );
    modport sink (
        input  valid, kind, corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y, night_now, seconds_of_day,
        output ready
    );
endinterface

interface rmoa_res_if
    import rmoa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HITS_W-1:0] region_hits;
    logic              any_hit;

    modport source (output valid, region_hits, any_hit, input ready);
    modport sink (input valid, region_hits, any_hit, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rmoa_front.sv
// Front end: takes requests, reduces corners to a bounding box, resolves the sensitivity set.
`timescale 1ns / 1ps
`default_nettype none
module rmoa_front
    import rmoa_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    rmoa_req_if.sink                       i_req,
    input  t_cfg                           i_cfg,
    input  logic                           i_q_full,
    output logic                           o_push,
    output logic [cmd_width(COORD_BITS)-1:0] o_cmd
);

    function automatic logic [COORD_BITS-1:0] to_coord(input logic [IN_COORD_W-1:0] v);
        logic [IN_COORD_W+COORD_BITS-1:0] w;
        w = {{COORD_BITS{1'b0}}, v};
        return w[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] cx [4];
    logic [COORD_BITS-1:0] cy [4];
    logic [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
    logic [SECS_W-1:0]     win_start, win_stop;
    t_dn_mode              mode;
    t_sens_sel             sel;

    always_comb begin
        cx[0] = to_coord(i_req.corner0_x);
        cy[0] = to_coord(i_req.corner0_y);
        cx[1] = to_coord(i_req.corner1_x);
        cy[1] = to_coord(i_req.corner1_y);
        cx[2] = to_coord(i_req.corner2_x);
        cy[2] = to_coord(i_req.corner2_y);
        cx[3] = to_coord(i_req.corner3_x);
        cy[3] = to_coord(i_req.corner3_y);
        min_x = cx[0];
        max_x = cx[0];
        min_y = cy[0];
        max_y = cy[0];
        for (int k = 1; k < 4; k++) begin
            if (cx[k] < min_x) min_x = cx[k];
            if (cx[k] > max_x) max_x = cx[k];
            if (cy[k] < min_y) min_y = cy[k];
            if (cy[k] > max_y) max_y = cy[k];
        end
    end

    assign mode      = t_dn_mode'(i_cfg.day_window[1:0]);
    assign win_start = i_cfg.day_window[2 +: SECS_W];
    assign win_stop  = i_cfg.day_window[2 + SECS_W +: SECS_W];

    always_comb begin
        unique case (mode)
            DN_OFF:   sel = SENS_CLOSE;
            DN_AUTO:  sel = i_req.night_now ? SENS_NIGHT : SENS_DAY;
            DN_SCHED: sel = (i_req.seconds_of_day >= win_start &&
                             i_req.seconds_of_day <= win_stop) ? SENS_DAY : SENS_NIGHT;
            default:  sel = SENS_NIGHT;
        endcase
    end

    assign i_req.ready = !i_q_full;
    // rectangles are dropped while disabled; end of frame always goes through to clear
    assign o_push = i_req.valid && !i_q_full && (i_req.kind == KIND_EOF || i_cfg.enable);
    assign o_cmd  = {i_req.kind, sel, min_x, max_x, min_y, max_y};

endmodule
`default_nettype wire

>>> hw/rtl/rmoa_queue.sv
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module rmoa_queue #(
    parameter int W = 51
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr, r_rptr;
    logic [1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            if (i_push && !i_pop)      r_count <= r_count + 2'd1;
            else if (i_pop && !i_push) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rptr];

endmodule
`default_nettype wire

>>> hw/rtl/rmoa_back.sv
// Back end: per-region sequencer, shared multiplier, accumulators and result register.
`timescale 1ns / 1ps
`default_nettype none
module rmoa_back
    import rmoa_pkg::*;
#(
    parameter int NUM_REGIONS = DEF_NUM_REGIONS,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cfg                             i_cfg,
    input  logic                             i_q_empty,
    input  logic [cmd_width(COORD_BITS)-1:0] i_q_data,
    output logic                             o_pop,
    rmoa_res_if.source                       o_res
);

    localparam int IDX_W  = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int CMD_W  = cmd_width(COORD_BITS);
    localparam int CB     = COORD_BITS;
    localparam int BW     = ((COORD_BITS > 8) ? COORD_BITS : 8) + 1;
    localparam int PW     = ACC_W + 1 + BW;
    localparam int LHS_W  = ACC_W + 7;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGIONS - 1);

    function automatic logic [CB-1:0] span(
        input logic [FIELD_W-1:0] r_lo,
        input logic [FIELD_W-1:0] r_len,
        input logic [CB-1:0]      b_lo,
        input logic [CB-1:0]      b_hi
    );
        logic [FIELD_W:0] lo, hi, a_lo, a_hi, bl, bh, d;
        a_lo = (FIELD_W+1)'(r_lo);
        a_hi = (FIELD_W+1)'(r_lo) + (FIELD_W+1)'(r_len);
        bl   = (FIELD_W+1)'(b_lo);
        bh   = (FIELD_W+1)'(b_hi);
        lo   = (a_lo > bl) ? a_lo : bl;
        hi   = (a_hi < bh) ? a_hi : bh;
        d    = (lo < hi) ? hi - lo : '0;
        return d[CB-1:0];
    endfunction

    // sequencer
    logic                r_busy;
    logic [IDX_W-1:0]    r_idx;
    logic [CMD_W-1:0]    r_cmd;
    logic                r_eof_busy;
    logic                last_issue, head_eof, start;

    // stage 1: spans or area/sensitivity
    logic                r_s1_valid, r_s1_eof, r_s1_last;
    logic [IDX_W-1:0]    r_s1_idx;
    logic [ACC_W-1:0]    r_s1_a;
    logic signed [BW-1:0] r_s1_b;

    // stage 2: product
    logic                r_s2_valid, r_s2_eof, r_s2_last, r_s2_nz;
    logic [IDX_W-1:0]    r_s2_idx;
    logic signed [PW-1:0] r_s2_prod;

    // stage 3: accumulate or compare
    logic [ACC_W-1:0]    r_acc [NUM_REGIONS];
    logic [HITS_W-1:0]   r_hits;
    logic                r_out_valid;
    logic [HITS_W-1:0]   r_out_hits;

    logic                cmd_eof;
    t_sens_sel           cmd_sel;
    logic [CB-1:0]       cmd_min_x, cmd_max_x, cmd_min_y, cmd_max_y;
    logic [BOUND_W-1:0]  rb;
    logic [FIELD_W-1:0]  rx, ry, rw, rh;
    logic [CB-1:0]       ov_x, ov_y;
    logic [ACC_W-1:0]    area;
    logic [SENS_W-1:0]   sens;
    logic signed [7:0]   sens_margin;
    logic [ACC_W-1:0]    n_s1_a;
    logic signed [BW-1:0] n_s1_b;
    logic signed [PW-1:0] n_s2_prod;
    logic [ACC_W-1:0]    acc_cur;
    logic [LHS_W-1:0]    lhs;
    logic [ACC_W:0]      sum;
    logic                hit;
    logic [HITS_W-1:0]   n_hits;

    assign head_eof   = i_q_data[CMD_W-1];
    assign last_issue = r_busy && (r_idx == LAST_IDX);
    // an end of frame waits until the result slot is free and no other one is in flight
    assign start = !i_q_empty && (!r_busy || last_issue) &&
                   (!head_eof || (!r_eof_busy && !r_out_valid));
    assign o_pop = start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (last_issue) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) r_cmd <= i_q_data;
    end

    // stage 1
    assign cmd_eof   = r_cmd[CMD_W-1];
    assign cmd_sel   = t_sens_sel'(r_cmd[4*CB +: 2]);
    assign cmd_min_x = r_cmd[3*CB +: CB];
    assign cmd_max_x = r_cmd[2*CB +: CB];
    assign cmd_min_y = r_cmd[CB +: CB];
    assign cmd_max_y = r_cmd[0 +: CB];

    assign rb = i_cfg.region_bounds[REGION_IDX_W'(r_idx)];
    assign rx = rb[0 +: FIELD_W];
    assign ry = rb[FIELD_W +: FIELD_W];
    assign rw = rb[2*FIELD_W +: FIELD_W];
    assign rh = rb[3*FIELD_W +: FIELD_W];

    assign ov_x = span(rx, rw, cmd_min_x, cmd_max_x);
    assign ov_y = span(ry, rh, cmd_min_y, cmd_max_y);
    assign area = rw * rh;

    always_comb begin
        unique case (cmd_sel)
            SENS_CLOSE: sens = i_cfg.sens_close_day[SENS_W*int'(r_idx) +: SENS_W];
            SENS_DAY:   sens = i_cfg.sens_close_day[SENS_SET_W + SENS_W*int'(r_idx) +: SENS_W];
            default:    sens = i_cfg.sens_night[SENS_W*int'(r_idx) +: SENS_W];
        endcase
    end

    // 100 - sens, negative for sensitivities above 100
    assign sens_margin = 8'sd100 - $signed({1'b0, sens});
    assign n_s1_a = cmd_eof ? area : ACC_W'(ov_x);
    assign n_s1_b = cmd_eof ? BW'(sens_margin) : $signed(BW'(ov_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_eof  <= cmd_eof;
        r_s1_last <= r_idx == LAST_IDX;
        r_s1_idx  <= r_idx;
        r_s1_a    <= n_s1_a;
        r_s1_b    <= n_s1_b;
    end

    // stage 2: shared multiplier, overlap area or threshold
    assign n_s2_prod = PW'($signed({1'b0, r_s1_a})) * PW'(r_s1_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_eof  <= r_s1_eof;
        r_s2_last <= r_s1_last;
        r_s2_idx  <= r_s1_idx;
        r_s2_nz   <= |r_s1_a;
        r_s2_prod <= n_s2_prod;
    end

    // stage 3
    assign acc_cur = r_acc[r_s2_idx];
    assign lhs = (LHS_W'(acc_cur) << 6) + (LHS_W'(acc_cur) << 5) + (LHS_W'(acc_cur) << 2);
    assign hit = r_s2_nz && ($signed(PW'(lhs)) > r_s2_prod);
    assign sum = {1'b0, acc_cur} + {1'b0, r_s2_prod[ACC_W-1:0]};
    assign n_hits = ((r_s2_idx == '0) ? '0 : r_hits) | (HITS_W'(hit) << r_s2_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGIONS; i++) r_acc[i] <= '0;
            r_eof_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (start && head_eof) r_eof_busy <= 1'b1;
            if (r_s2_valid) begin
                if (r_s2_eof) r_acc[r_s2_idx] <= '0;
                else          r_acc[r_s2_idx] <= sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            end
            if (r_s2_valid && r_s2_eof && r_s2_last) begin
                r_eof_busy  <= 1'b0;
                r_out_valid <= i_cfg.enable;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && r_s2_eof) r_hits <= n_hits;
        if (r_s2_valid && r_s2_eof && r_s2_last) r_out_hits <= n_hits;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.region_hits = r_out_hits;
    assign o_res.any_hit     = |r_out_hits;

endmodule
`default_nettype wire

>>> hw/rtl/region_motion_overlap_alarm_core.sv
// Top level of the region motion overlap alarm.
// Motion rectangle requests are reduced to bounding boxes in the front end and queued;
// the back end walks the regions one per cycle through a three-stage pipe with a shared
// multiplier, and a new rectangle can start as soon as the last region of the one before
// it is issued. With detection disabled a rectangle is dropped at the front. An end of
// frame also walks every region, its result passes the stage 1, stage 2 and result
// registers after its last region is issued, and it is not started while an earlier
// result is still waiting to be taken. The result register decouples the output so
// requests keep flowing while a result waits. The user must write configuration through
// i_cfg_we/i_cfg_idx/i_cfg_data only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module region_motion_overlap_alarm_core
    import rmoa_pkg::*;
#(
    parameter int NUM_REGIONS = DEF_NUM_REGIONS,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rmoa_req_if.sink              i_req,
    rmoa_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CMD_W = cmd_width(COORD_BITS);

    t_cfg             r_cfg;
    logic             q_push, q_full, q_pop, q_empty;
    logic [CMD_W-1:0] q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:     r_cfg.enable           <= i_cfg_data[0];
                CFG_REGION0:    r_cfg.region_bounds[0] <= i_cfg_data;
                CFG_REGION1:    r_cfg.region_bounds[1] <= i_cfg_data;
                CFG_REGION2:    r_cfg.region_bounds[2] <= i_cfg_data;
                CFG_REGION3:    r_cfg.region_bounds[3] <= i_cfg_data;
                CFG_SENS_CD:    r_cfg.sens_close_day   <= i_cfg_data[2*SENS_SET_W-1:0];
                CFG_SENS_NIGHT: r_cfg.sens_night       <= i_cfg_data[SENS_SET_W-1:0];
                CFG_DAY_WINDOW: r_cfg.day_window       <= i_cfg_data[DAY_WIN_W-1:0];
                default:        ;
            endcase
        end
    end

    rmoa_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    rmoa_queue #(
        .W (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    rmoa_back #(
        .NUM_REGIONS (NUM_REGIONS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

>>> hw/rtl/rmoa_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rmoa_checker
    import rmoa_pkg::*;
#(
    parameter int NUM_REGIONS = DEF_NUM_REGIONS
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [HITS_W-1:0] i_region_hits,
    input logic              i_any_hit
);

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_region_hits))
        else $error("result changed while stalled");

    a_any_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_any_hit == (i_region_hits != '0)))
        else $error("any flag disagrees with hit mask");

    a_unused_regions_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> ((i_region_hits >> NUM_REGIONS) == '0))
        else $error("hit reported for a region that does not exist");

endmodule

bind region_motion_overlap_alarm_core rmoa_checker #(
    .NUM_REGIONS (NUM_REGIONS)
) u_rmoa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_region_hits (o_res.region_hits),
    .i_any_hit     (o_res.any_hit)
);
`default_nettype wire

>>> verif/tb.sv
// Testbench for region_motion_overlap_alarm_core: random frames checked against a predictor.
`timescale 1ns / 1ps
module tb;
    import rmoa_pkg::*;

    localparam int NREG          = DEF_NUM_REGIONS;
    localparam int CMASK         = (1 << DEF_COORD_BITS) - 1;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_SECS      = 86399;
    localparam logic [1:0] DN_NIGHT_ONLY = 2'd3;  // mode outside the enum: night set always

    typedef struct packed {
        logic             kind;
        logic [3:0][11:0] cx;
        logic [3:0][11:0] cy;
        logic             night;
        logic [16:0]      secs;
    } t_motion_req;

    typedef struct packed {
        logic [HITS_W-1:0] hits;
        logic              any_hit;
    } t_alarm_result;

    // Predicts alarm results from accepted requests and holds them until they come out.
    class overlap_alarm_model;
        bit            enabled;
        bit [63:0]     bounds [MAX_REGIONS];
        bit [55:0]     sens_cd;
        bit [27:0]     sens_nt;
        bit [35:0]     day_win;
        bit [31:0]     overlap_acc [MAX_REGIONS];
        t_alarm_result pending_alarms [$];
        int            errors;

        function void write_reg(t_cfg_idx idx, logic [63:0] data);
            case (idx)
                CFG_ENABLE:     enabled = data[0];
                CFG_REGION0, CFG_REGION1, CFG_REGION2, CFG_REGION3:
                    bounds[idx - CFG_REGION0] = data;
                CFG_SENS_CD:    sens_cd = data[55:0];
                CFG_SENS_NIGHT: sens_nt = data[27:0];
                CFG_DAY_WINDOW: day_win = data[35:0];
                default: ;
            endcase
        endfunction

        function longint unsigned span_len(longint unsigned a0, longint unsigned a1,
                                           longint unsigned b0, longint unsigned b1);
            longint unsigned lo, hi;
            lo = (a0 > b0) ? a0 : b0;
            hi = (a1 < b1) ? a1 : b1;
            return (lo < hi) ? hi - lo : 0;
        endfunction

        function void take_request(t_motion_req r);
            longint unsigned lo_x, hi_x, lo_y, hi_y, px, py;
            longint unsigned rx, ry, rw, rh, ov, sum;
            longint          area, sens, acc;
            logic [1:0]      mode;
            logic [16:0]     start_s, stop_s;
            bit              day;
            t_sens_sel       sel;
            logic [3:0]      hits;
            t_alarm_result   res;
            if (r.kind == KIND_RECT) begin
                if (!enabled) return;
                lo_x = r.cx[0] & CMASK;
                hi_x = lo_x;
                lo_y = r.cy[0] & CMASK;
                hi_y = lo_y;
                for (int k = 1; k < 4; k++) begin
                    px = r.cx[k] & CMASK;
                    py = r.cy[k] & CMASK;
                    if (px < lo_x) lo_x = px;
                    if (px > hi_x) hi_x = px;
                    if (py < lo_y) lo_y = py;
                    if (py > hi_y) hi_y = py;
                end
                for (int i = 0; i < NREG; i++) begin
                    rx = bounds[i][15:0];
                    ry = bounds[i][31:16];
                    rw = bounds[i][47:32];
                    rh = bounds[i][63:48];
                    if (rw * rh == 0) continue;
                    ov = span_len(rx, rx + rw, lo_x, hi_x) * span_len(ry, ry + rh, lo_y, hi_y);
                    sum = overlap_acc[i] + ov;
                    overlap_acc[i] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                end
            end else begin
                mode    = day_win[1:0];
                start_s = day_win[18:2];
                stop_s  = day_win[35:19];
                day     = 1'b0;
                if (mode == DN_AUTO)
                    day = !r.night;
                else if (mode == DN_SCHED)
                    day = (r.secs >= start_s) && (r.secs <= stop_s);
                if (mode == DN_OFF)
                    sel = SENS_CLOSE;
                else if (day)
                    sel = SENS_DAY;
                else
                    sel = SENS_NIGHT;
                hits = '0;
                for (int i = 0; i < NREG; i++) begin
                    rw   = bounds[i][47:32];
                    rh   = bounds[i][63:48];
                    area = rw * rh;
                    acc  = overlap_acc[i];
                    case (sel)
                        SENS_CLOSE: sens = sens_cd[7*i +: 7];
                        SENS_DAY:   sens = sens_cd[28 + 7*i +: 7];
                        default:    sens = sens_nt[7*i +: 7];
                    endcase
                    // signed compare: sensitivity above 100 fires on any non-empty region
                    if (area > 0 && acc * 100 > area * (100 - sens))
                        hits[i] = 1'b1;
                end
                for (int i = 0; i < MAX_REGIONS; i++)
                    overlap_acc[i] = '0;
                if (enabled) begin
                    res.hits    = hits;
                    res.any_hit = (hits != 0);
                    pending_alarms.push_back(res);
                end
            end
        endfunction

        function void note_mismatch(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t mismatch: %s", $time, msg);
        endfunction

        function void check_alarm(logic [HITS_W-1:0] hits, logic any_flag);
            t_alarm_result want;
            if (pending_alarms.size() == 0) begin
                note_mismatch($sformatf("unexpected result hits=%h any_hit=%b", hits, any_flag));
                return;
            end
            want = pending_alarms.pop_front();
            if (hits !== want.hits)
                note_mismatch($sformatf("region_hits expected %h got %h", want.hits, hits));
            if (any_flag !== want.any_hit)
                note_mismatch($sformatf("any_hit expected %b got %b", want.any_hit, any_flag));
        endfunction

        function int pending();
            return pending_alarms.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rmoa_req_if req_if ();
    rmoa_res_if res_if ();

    region_motion_overlap_alarm_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_res     (res_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    overlap_alarm_model book = new();

    bit send_relaxed;
    bit recv_relaxed;
    bit hold_results;

    // configuration the next phase will program
    bit        cur_en;
    bit [63:0] cur_bounds [MAX_REGIONS];
    bit [55:0] cur_scd;
    bit [27:0] cur_sn;
    bit [35:0] cur_dw;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit [63:0] region_word(int x, int y, int w, int h);
        return {16'(h), 16'(w), 16'(y), 16'(x)};
    endfunction

    function automatic bit [27:0] sens_set(int s0, int s1, int s2, int s3);
        return {7'(s3), 7'(s2), 7'(s1), 7'(s0)};
    endfunction

    function automatic bit [35:0] day_window_word(bit [1:0] mode, int start_s, int stop_s);
        return {17'(stop_s), 17'(start_s), mode};
    endfunction

    function automatic bit [6:0] rand_sens();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 7'($urandom_range(101, 127));
        if (pick == 1) return ($urandom_range(0, 1) != 0) ? 7'd0 : 7'd100;
        return 7'($urandom_range(0, 100));
    endfunction

    function automatic bit [63:0] rand_region();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return {$urandom, $urandom};
        if (pick == 1)
            return ($urandom_range(0, 1) != 0)
                ? region_word($urandom_range(0, 4095), $urandom_range(0, 4095), 0,
                              $urandom_range(0, 4095))
                : region_word($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), 0);
        if (pick == 2)
            return region_word($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(1, 4095), $urandom_range(1, 4095));
        return region_word($urandom_range(0, 3800), $urandom_range(0, 3800),
                           $urandom_range(1, 1200), $urandom_range(1, 1200));
    endfunction

    function automatic t_motion_req box_request(int x0, int y0, int x1, int y1);
        t_motion_req r;
        int px [4];
        int py [4];
        int rot;
        px  = '{x0, x1, x1, x0};
        py  = '{y0, y0, y1, y1};
        rot = $urandom_range(0, 3);
        r.kind = KIND_RECT;
        for (int j = 0; j < 4; j++) begin
            r.cx[j] = 12'(px[(j + rot) % 4]);
            r.cy[j] = 12'(py[(j + rot) % 4]);
        end
        r.night = 1'($urandom);
        r.secs  = 17'($urandom);
        return r;
    endfunction

    function automatic t_motion_req random_rect();
        t_motion_req r;
        int pick, x0, y0, x1, y1;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            // arbitrary corner points, not a proper rectangle
            r.kind = KIND_RECT;
            for (int j = 0; j < 4; j++) begin
                r.cx[j] = 12'($urandom);
                r.cy[j] = 12'($urandom);
            end
            r.night = 1'($urandom);
            r.secs  = 17'($urandom);
            return r;
        end
        if (pick == 2) return box_request(0, 0, 4095, 4095);
        x0 = $urandom_range(0, 4095);
        y0 = $urandom_range(0, 4095);
        x1 = x0 + $urandom_range(0, 1500);
        y1 = y0 + $urandom_range(0, 1500);
        if (x1 > 4095) x1 = 4095;
        if (y1 > 4095) y1 = 4095;
        if ($urandom_range(0, 1) != 0) return box_request(x1, y1, x0, y0);
        return box_request(x0, y0, x1, y1);
    endfunction

    function automatic t_motion_req frame_end(bit night, int secs);
        t_motion_req r;
        r.kind = KIND_EOF;
        for (int j = 0; j < 4; j++) begin
            r.cx[j] = 12'($urandom);
            r.cy[j] = 12'($urandom);
        end
        r.night = night;
        r.secs  = 17'(secs);
        return r;
    endfunction

    function automatic t_motion_req random_frame_end();
        int pick, secs;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            secs = cur_dw[18:2];
        else if (pick < 6)
            secs = cur_dw[35:19];
        else if (pick == 6)
            secs = cur_dw[18:2] - 1;
        else if (pick == 7)
            secs = cur_dw[35:19] + 1;
        else if (pick < 10)
            secs = $urandom_range(0, 131071);
        else
            secs = $urandom_range(0, MAX_SECS);
        return frame_end(1'($urandom), secs);
    endfunction

    task automatic send_request(input t_motion_req r);
        int gap;
        gap = send_relaxed ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.kind           <= r.kind;
        req_if.corner0_x      <= r.cx[0];
        req_if.corner0_y      <= r.cy[0];
        req_if.corner1_x      <= r.cx[1];
        req_if.corner1_y      <= r.cy[1];
        req_if.corner2_x      <= r.cx[2];
        req_if.corner2_y      <= r.cy[2];
        req_if.corner3_x      <= r.cx[3];
        req_if.corner3_y      <= r.cy[3];
        req_if.night_now      <= r.night;
        req_if.seconds_of_day <= r.secs;
        req_if.valid          <= 1'b1;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        book.take_request(r);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        book.write_reg(idx, data);
    endtask

    // unused upper bits carry random junk that the block must drop
    task automatic load_config();
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_ENABLE, {junk[63:1], cur_en});
        for (int i = 0; i < MAX_REGIONS; i++)
            write_reg(t_cfg_idx'(CFG_REGION0 + i), cur_bounds[i]);
        write_reg(CFG_SENS_CD, {junk[63:56], cur_scd});
        write_reg(CFG_SENS_NIGHT, {junk[63:28], cur_sn});
        write_reg(CFG_DAY_WINDOW, {junk[63:36], cur_dw});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    // idle point: results in, and time for rectangles that produce nothing
    task automatic settle();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input bit long_hold);
        int sent, nrect;
        cur_en = long_hold || ($urandom_range(0, 9) != 0);
        for (int i = 0; i < MAX_REGIONS; i++)
            cur_bounds[i] = rand_region();
        cur_scd = {sens_set(rand_sens(), rand_sens(), rand_sens(), rand_sens()),
                   sens_set(rand_sens(), rand_sens(), rand_sens(), rand_sens())};
        cur_sn  = sens_set(rand_sens(), rand_sens(), rand_sens(), rand_sens());
        if ($urandom_range(0, 9) == 0)
            cur_dw = 36'({$urandom, $urandom});
        else
            cur_dw = day_window_word(2'($urandom_range(0, 3)), $urandom_range(0, MAX_SECS),
                                     $urandom_range(0, MAX_SECS));
        load_config();
        send_relaxed = long_hold || ($urandom_range(0, 3) == 0);
        recv_relaxed = $urandom_range(0, 3) == 0;
        if (long_hold) hold_results = 1'b1;
        sent = 0;
        while (sent < n_items) begin
            nrect = $urandom_range(0, 8);
            repeat (nrect) send_request(random_rect());
            send_request(random_frame_end());
            sent += nrect + 1;
            if ($urandom_range(0, 19) == 0) wait_all_results();
        end
        settle();
    endtask

    initial begin : result_sink
        int gap;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end
            gap = recv_relaxed ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
            book.check_alarm(res_if.region_hits, res_if.any_hit);
        end
    end

    initial begin : stimulus
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_ENABLE;
        i_cfg_data            = '0;
        req_if.valid          = 1'b0;
        req_if.kind           = KIND_RECT;
        req_if.corner0_x      = '0;
        req_if.corner0_y      = '0;
        req_if.corner1_x      = '0;
        req_if.corner1_y      = '0;
        req_if.corner2_x      = '0;
        req_if.corner2_y      = '0;
        req_if.corner3_x      = '0;
        req_if.corner3_y      = '0;
        req_if.night_now      = 1'b0;
        req_if.seconds_of_day = '0;
        send_relaxed          = 1'b0;
        recv_relaxed          = 1'b0;
        hold_results          = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset detection is off: frame end clears but reports nothing
        send_request(box_request(0, 0, 4095, 4095));
        send_request(frame_end(1'b1, MAX_SECS));
        settle();

        // close set; one empty region, one with sensitivity above 100
        cur_en        = 1'b1;
        cur_bounds[0] = region_word(100, 100, 200, 200);
        cur_bounds[1] = region_word(0, 0, 4095, 4095);
        cur_bounds[2] = region_word(50, 50, 0, 300);
        cur_bounds[3] = region_word(4000, 4000, 95, 95);
        cur_scd       = {sens_set(30, 60, 90, 10), sens_set(0, 100, 50, 127)};
        cur_sn        = sens_set(100, 1, 127, 70);
        cur_dw        = day_window_word(DN_OFF, 0, 0);
        load_config();
        send_request(box_request(0, 0, 0, 0));
        send_request(box_request(4095, 4095, 4095, 4095));
        send_request(box_request(0, 0, 4095, 4095));
        send_request(box_request(250, 250, 150, 150));
        send_request(frame_end(1'b1, MAX_SECS));
        settle();

        // light sensor picks day or night
        cur_dw = day_window_word(DN_AUTO, 0, 0);
        load_config();
        send_request(box_request(120, 80, 700, 350));
        send_request(frame_end(1'b0, 0));
        send_request(box_request(0, 0, 4095, 4095));
        send_request(frame_end(1'b1, 0));
        settle();

        // schedule edges and a time past the end of the day
        cur_dw = day_window_word(DN_SCHED, 3600, 72000);
        load_config();
        send_request(box_request(90, 90, 320, 4095));
        send_request(frame_end(1'b1, 3600));
        send_request(frame_end(1'b1, 72000));
        send_request(frame_end(1'b0, 3599));
        send_request(frame_end(1'b0, 131071));
        settle();

        // region running past the frame edge, night set forced
        cur_bounds[3] = region_word(4000, 0, 65535, 65535);
        cur_dw        = day_window_word(DN_NIGHT_ONLY, 0, MAX_SECS);
        load_config();
        send_request(box_request(3000, 0, 4095, 4095));
        send_request(frame_end(1'b0, 100));
        settle();

        for (int p = 0; p < 20; p++) begin
            if (p == 9) begin
                // enough full-frame boxes to drive the accumulators into saturation
                cur_en        = 1'b1;
                cur_bounds[0] = region_word(0, 0, 65535, 65535);
                cur_bounds[1] = region_word(0, 0, 4095, 4095);
                cur_bounds[2] = region_word(0, 0, 0, 0);
                cur_bounds[3] = region_word(4095, 4095, 65535, 65535);
                cur_scd       = '0;
                cur_sn        = '0;
                cur_dw        = day_window_word(DN_OFF, 0, 0);
                load_config();
                send_relaxed = 1'b1;
                recv_relaxed = 1'b0;
                repeat (260) send_request(box_request(0, 0, 4095, 4095));
                send_request(frame_end(1'b0, 0));
                settle();
            end
            run_phase($urandom_range(60, 100), p == 4);
        end

        settle();
        if (book.pending() != 0)
            $display("%0d expected results never arrived", book.pending());
        if (book.errors == 0 && book.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
